>>> rtl/rpe_pkg.sv
// Shared types, constants and register indexes for the rumble payload encoder.
`timescale 1ns / 1ps

package rpe_pkg;

    // Field widths
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned GAIN_W  = 7;
    localparam int unsigned AMP_W   = 16;
    localparam int unsigned LANE_W  = 10;
    localparam int unsigned PAY_W   = 40;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 2;

    // Gain stage: level * gain + 50, then divide by 100
    localparam int unsigned GPROD_W    = 15;
    localparam logic [GPROD_W-1:0] GAIN_ROUND = GPROD_W'(50);
    localparam logic [GAIN_W-1:0]  GAIN_MAX   = GAIN_W'(100);
    localparam logic [GPROD_W-1:0] DIV100     = GPROD_W'(100);
    // floor(2^22 / 100); the estimate is low by at most one
    localparam int unsigned DIV100_SH  = 22;
    localparam int unsigned DIV100_MW  = 16;
    localparam logic [DIV100_MW-1:0] DIV100_M = DIV100_MW'(41943);
    localparam int unsigned G_MUL_W    = GPROD_W + DIV100_MW;

    // Amplitude: level * max_amplitude + 127, then divide by 255
    localparam int unsigned APROD_W   = 24;
    localparam int unsigned DIVA_SH   = 32;
    localparam int unsigned DIVA_MW   = 25;
    localparam logic [DIVA_MW-1:0] DIVA_M = DIVA_MW'(16843009);  // floor(2^32 / 255)
    localparam int unsigned A_MUL_W   = APROD_W + DIVA_MW;

    // Frequency: span * level + 127, then divide by 255
    localparam int unsigned FPROD_W   = 16;
    localparam int unsigned DIVF_SH   = 24;
    localparam int unsigned DIVF_MW   = 17;
    localparam logic [DIVF_MW-1:0] DIVF_M = DIVF_MW'(65793);     // floor(2^24 / 255)
    localparam int unsigned F_MUL_W   = FPROD_W + DIVF_MW;
    localparam int unsigned FQ_W      = 8;

    localparam logic [7:0] ROUND_255 = 8'd127;
    localparam logic [7:0] DIV255    = 8'd255;

    // Frequency bands and defaults
    localparam logic [LANE_W-1:0] LOW_FREQ_DEF  = LANE_W'(12'h0e1);
    localparam logic [LANE_W-1:0] HIGH_FREQ_DEF = LANE_W'(12'h1e1);
    localparam logic [LANE_W-1:0] LOW_BAND_MIN  = LANE_W'(12'h0b8);
    localparam logic [LANE_W-1:0] LOW_BAND_MAX  = LANE_W'(12'h122);
    localparam logic [LANE_W-1:0] HIGH_BAND_MIN = LANE_W'(12'h160);
    localparam logic [LANE_W-1:0] HIGH_BAND_MAX = LANE_W'(12'h1f0);
    localparam logic [7:0] LOW_SPAN  = 8'(LOW_BAND_MAX - LOW_BAND_MIN);
    localparam logic [7:0] HIGH_SPAN = 8'(HIGH_BAND_MAX - HIGH_BAND_MIN);

    // Reset values
    localparam logic [GAIN_W-1:0] GAIN_RST    = GAIN_W'(100);
    localparam logic [AMP_W-1:0]  MAX_AMP_RST = AMP_W'(1023);

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_LEFT_GAIN  = 2'd0,
        CFG_RIGHT_GAIN = 2'd1,
        CFG_MAX_AMP    = 2'd2
    } t_cfg_idx;

    // Beat payloads
    typedef struct packed {
        logic [LEVEL_W-1:0] weak_level;
        logic [LEVEL_W-1:0] strong_level;
    } t_in_beat;

    typedef struct packed {
        logic [PAY_W-1:0] left_payload;
        logic [PAY_W-1:0] right_payload;
    } t_out_beat;

endpackage

>>> rtl/rumble_payload_encoder_top.sv
// Six-stage pipeline that maps a motor level pair to two vibration payloads.
`timescale 1ns / 1ps

// Rumble payload encoder.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one beat with a
// weak and a strong motor level. Output channel (o_out_valid / i_out_ready /
// o_out_data) returns one beat per input beat with the left and right 40-bit
// payloads, in input order.
// Pipeline: six register stages, the last one is the output register; the
// accepting edge loads the first.
// Throughput: one beat per cycle while the receiver takes beats; every stage
// holds one beat, and the divides by 100 and 255 are reciprocal multiplies
// followed by a one-step correction in the next stage.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 left
// gain, 1 right gain, 2 max amplitude) in the same cycle. Gains (bits 6:0)
// saturate over 100; index 3 is ignored. Write only while the pipeline is empty.
// Reset (synchronous, active low) empties the pipeline and sets both gains to
// 100 and max amplitude to 1023.
// When the receiver stalls, beats pile up stage by stage; o_in_ready drops
// only once all six stages hold a beat. Nothing is dropped or repeated.
module rumble_payload_encoder_top
    import rpe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_beat         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_beat        o_out_data
);

    // Index convention: side 0 left, 1 right; lane 0 weak (high band),
    // lane 1 strong (low band).

    // Configuration registers
    logic [GAIN_W-1:0] r_gain [2];
    logic [AMP_W-1:0]  r_max_amp;
    logic [GAIN_W-1:0] n_gain_wr;

    assign n_gain_wr = (i_cfg_data[GAIN_W-1:0] > GAIN_MAX) ? GAIN_MAX
                                                           : i_cfg_data[GAIN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain[0] <= GAIN_RST;
            r_gain[1] <= GAIN_RST;
            r_max_amp <= MAX_AMP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEFT_GAIN:  r_gain[0] <= n_gain_wr;
                CFG_RIGHT_GAIN: r_gain[1] <= n_gain_wr;
                CFG_MAX_AMP:    r_max_amp <= i_cfg_data[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage valids and enables: a stage loads when it is empty or moves on
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !r_v6 || i_out_ready;
    assign en5 = !r_v5 || en6;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_ready  = en1;
    assign o_out_valid = r_v6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    // Payload registers
    logic [GPROD_W-1:0] r_gp1 [2][2];   // stage 1: level * gain + 50
    logic [GPROD_W-1:0] r_gp2 [2][2];   // stage 2: copy for correction
    logic [LEVEL_W-1:0] r_gq2 [2][2];   // stage 2: quotient estimate
    logic [LEVEL_W-1:0] r_lv3 [2][2];   // stage 3: scaled level
    logic [APROD_W-1:0] r_ap4 [2][2];   // stage 4: amplitude numerator
    logic [FPROD_W-1:0] r_fp4 [2][2];   // stage 4: frequency numerator
    logic [APROD_W-1:0] r_ap5 [2][2];
    logic [FPROD_W-1:0] r_fp5 [2][2];
    logic [AMP_W-1:0]   r_aq5 [2][2];   // stage 5: amplitude estimate
    logic [FQ_W-1:0]    r_fq5 [2][2];   // stage 5: frequency offset estimate
    logic [PAY_W-1:0]   r_pay6 [2];     // stage 6: output register

    // Combinational next values
    logic [GPROD_W-1:0] n_gp   [2][2];
    logic [G_MUL_W-1:0] n_gmul [2][2];
    logic [GPROD_W-1:0] n_grem [2][2];
    logic [LEVEL_W-1:0] n_lv   [2][2];
    logic [APROD_W-1:0] n_ap   [2][2];
    logic [FPROD_W-1:0] n_fp   [2][2];
    logic [A_MUL_W-1:0] n_amul [2][2];
    logic [F_MUL_W-1:0] n_fmul [2][2];
    logic [APROD_W-1:0] n_arem [2][2];
    logic [FPROD_W-1:0] n_frem [2][2];
    logic [AMP_W-1:0]   n_amp  [2][2];
    logic [FQ_W-1:0]    n_fq   [2][2];
    logic [LANE_W-1:0]  n_freq [2][2];
    logic [PAY_W-1:0]   n_pay  [2];

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            for (int l = 0; l < 2; l++) begin
                // stage 1: gain product with rounding term
                n_gp[s][l] = GPROD_W'((l == 0) ? i_in_data.weak_level
                                               : i_in_data.strong_level)
                           * GPROD_W'(r_gain[s]) + GAIN_ROUND;
                // stage 2: reciprocal multiply for / 100
                n_gmul[s][l] = G_MUL_W'(r_gp1[s][l]) * G_MUL_W'(DIV100_M);
                // stage 3: fix the estimate up by one where the remainder allows
                n_grem[s][l] = r_gp2[s][l] - GPROD_W'(r_gq2[s][l]) * DIV100;
                n_lv[s][l]   = r_gq2[s][l] + LEVEL_W'(n_grem[s][l] >= DIV100);
                // stage 4: amplitude and frequency numerators
                n_ap[s][l] = APROD_W'(r_lv3[s][l]) * APROD_W'(r_max_amp)
                           + APROD_W'(ROUND_255);
                n_fp[s][l] = FPROD_W'((l == 0) ? HIGH_SPAN : LOW_SPAN)
                           * FPROD_W'(r_lv3[s][l]) + FPROD_W'(ROUND_255);
                // stage 5: reciprocal multiplies for / 255
                n_amul[s][l] = A_MUL_W'(r_ap4[s][l]) * A_MUL_W'(DIVA_M);
                n_fmul[s][l] = F_MUL_W'(r_fp4[s][l]) * F_MUL_W'(DIVF_M);
                // stage 6: correction, default frequency on zero amplitude
                n_arem[s][l] = r_ap5[s][l] - APROD_W'(r_aq5[s][l]) * APROD_W'(DIV255);
                n_amp[s][l]  = r_aq5[s][l] + AMP_W'(n_arem[s][l] >= APROD_W'(DIV255));
                n_frem[s][l] = r_fp5[s][l] - FPROD_W'(r_fq5[s][l]) * FPROD_W'(DIV255);
                n_fq[s][l]   = r_fq5[s][l] + FQ_W'(n_frem[s][l] >= FPROD_W'(DIV255));
                if (n_amp[s][l] == '0) begin
                    n_freq[s][l] = (l == 0) ? HIGH_FREQ_DEF : LOW_FREQ_DEF;
                end else begin
                    n_freq[s][l] = ((l == 0) ? HIGH_BAND_MIN : LOW_BAND_MIN)
                                 + LANE_W'(n_fq[s][l]);
                end
            end
            // Zero levels give zero amplitudes and default frequencies,
            // which is the idle payload, so no separate path is needed.
            n_pay[s] = {n_amp[s][0][LANE_W-1:0], n_freq[s][0],
                        n_amp[s][1][LANE_W-1:0], n_freq[s][1]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < 2; s++) begin
            for (int l = 0; l < 2; l++) begin
                if (en1) begin
                    r_gp1[s][l] <= n_gp[s][l];
                end
                if (en2) begin
                    r_gp2[s][l] <= r_gp1[s][l];
                    r_gq2[s][l] <= n_gmul[s][l][DIV100_SH +: LEVEL_W];
                end
                if (en3) begin
                    r_lv3[s][l] <= n_lv[s][l];
                end
                if (en4) begin
                    r_ap4[s][l] <= n_ap[s][l];
                    r_fp4[s][l] <= n_fp[s][l];
                end
                if (en5) begin
                    r_ap5[s][l] <= r_ap4[s][l];
                    r_fp5[s][l] <= r_fp4[s][l];
                    r_aq5[s][l] <= n_amul[s][l][DIVA_SH +: AMP_W];
                    r_fq5[s][l] <= n_fmul[s][l][DIVF_SH +: FQ_W];
                end
            end
            if (en6) begin
                r_pay6[s] <= n_pay[s];
            end
        end
    end

    assign o_out_data.left_payload  = r_pay6[0];
    assign o_out_data.right_payload = r_pay6[1];

endmodule
